### sv/blpwm_pkg.sv
// ----------------------------------------------------------------------------
// blpwm_pkg
// Types and constants shared by the backlight PWM level converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package blpwm_pkg;

  localparam int ALU_W = 49;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CFG_PWM_PERIOD        = 2'd0;
  localparam logic [1:0] CFG_PERIOD_BIT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_FRACTIONAL_ENABLE = 2'd2;

  localparam logic [15:0] RST_PWM_PERIOD        = 16'd4000;
  localparam logic [3:0]  RST_PERIOD_BIT_COUNT  = 4'd12;
  localparam logic        RST_FRACTIONAL_ENABLE = 1'b1;

  localparam logic [15:0] DIV_ZERO_SUBST = 16'hFFFF;

  typedef struct packed {
    logic        command;
    logic [31:0] level;
  } cmd_t;

  typedef struct packed {
    logic [31:0] level_readback;
    logic [15:0] duty_count;
  } res_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

### sv/blpwm_alu.sv
// ----------------------------------------------------------------------------
// blpwm_alu
// Shared adder and subtractor used by every step of the converter sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module blpwm_alu (
  input  blpwm_pkg::alu_req_t            req,
  output logic [blpwm_pkg::ALU_W-1:0]    sum
);
  import blpwm_pkg::*;

  assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

`default_nettype wire

### sv/backlight_pwm_level_converter_unit.sv
// ----------------------------------------------------------------------------
// backlight_pwm_level_converter_unit
// Converts an unsigned level with period_bit_count fraction bits to a PWM
// duty count and back again, using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// set request: 16 shift-add multiply steps plus one rounding step; the result is
//   registered from S_FIN once the output register is free.
// read request: 33 restoring divide steps plus one rounding step; the result is
//   registered from S_FIN once the output register is free.
// one request in flight; the output register lets the next request start.
// synchronous reset clears the duty store and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module backlight_pwm_level_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  blpwm_pkg::cmd_t    cmd_data,
  output logic               res_valid,
  input  logic               res_stall,
  output blpwm_pkg::res_t    res_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import blpwm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic        cmd_r;
  logic [31:0] level_r;
  logic [4:0]  bits_r;
  logic [15:0] period_r;
  logic [15:0] divisor;
  logic [47:0] acc;
  logic [32:0] dvd;
  logic [15:0] rem;
  logic [32:0] quo;
  logic [15:0] active_duty;
  logic [15:0] pwm_period;
  logic [3:0]  period_bit_count;
  logic        fractional_enable;

  logic [4:0]       bits_in;
  logic [15:0]      bmask;
  logic [15:0]      pmask;
  logic [15:0]      period_in;
  logic [15:0]      duty_in;
  logic [32:0]      dvd_in;
  logic [47:0]      acc_shr;
  logic [47:0]      acc_rnd;
  logic [15:0]      rem_sh;
  logic             borrow;
  logic             res_free;
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_sum;

  blpwm_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  // field decode for the request being accepted
  always_comb begin
    bits_in   = (period_bit_count == 4'd0) ? 5'd16 : {1'b0, period_bit_count};
    bmask     = 16'((17'd1 << bits_in) - 17'd1);
    pmask     = bmask << (5'd16 - bits_in);
    period_in = pwm_period & bmask;
    duty_in   = fractional_enable ? active_duty : (active_duty & pmask);
    dvd_in    = 33'(duty_in) << (bits_in + 5'd1);
  end

  assign acc_shr  = acc >> bits_r;
  assign acc_rnd  = acc >> (bits_r - 5'd1);
  assign rem_sh   = {rem[14:0], dvd[32]};
  assign borrow   = alu_sum[ALU_W-1];
  assign res_free = !res_valid || !res_stall;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // operand selection for the shared adder
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_MUL: begin
        alu_req.sub = 1'b0;
        alu_req.a   = ALU_W'({acc[46:0], 1'b0});
        alu_req.b   = period_r[cnt[3:0]] ? ALU_W'(level_r) : '0;
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'({rem, dvd[32]});
        alu_req.b   = ALU_W'(divisor);
      end
      S_FIN: begin
        alu_req.sub = 1'b0;
        if (cmd_r == CMD_SET) begin
          alu_req.a = ALU_W'(acc_shr[15:0]);
          alu_req.b = ALU_W'(acc_rnd[0]);
        end else begin
          alu_req.a = ALU_W'(quo);
          alu_req.b = ALU_W'(1'b1);
        end
      end
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      res_valid         <= 1'b0;
      active_duty       <= '0;
      pwm_period        <= RST_PWM_PERIOD;
      period_bit_count  <= RST_PERIOD_BIT_COUNT;
      fractional_enable <= RST_FRACTIONAL_ENABLE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PWM_PERIOD:        pwm_period        <= cfg_data;
          CFG_PERIOD_BIT_COUNT:  period_bit_count  <= cfg_data[3:0];
          CFG_FRACTIONAL_ENABLE: fractional_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (res_valid && !res_stall && state != S_FIN) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r    <= cmd_data.command;
            level_r  <= cmd_data.level;
            bits_r   <= bits_in;
            period_r <= period_in;
            divisor  <= (period_in == 16'd0) ? DIV_ZERO_SUBST : period_in;
            acc      <= '0;
            rem      <= '0;
            quo      <= '0;
            dvd      <= dvd_in;
            if (cmd_data.command == CMD_SET) begin
              cnt   <= 6'd15;
              state <= S_MUL;
            end else begin
              cnt   <= 6'd32;
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          acc <= alu_sum[47:0];
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_DIV: begin
          rem <= borrow ? rem_sh : alu_sum[15:0];
          quo <= {quo[31:0], !borrow};
          dvd <= {dvd[31:0], 1'b0};
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_FIN: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
            if (cmd_r == CMD_SET) begin
              active_duty             <= alu_sum[15:0];
              res_data.level_readback <= '0;
              res_data.duty_count     <= alu_sum[15:0];
            end else begin
              res_data.level_readback <= alu_sum[32:1];
              res_data.duty_count     <= active_duty;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
